// File: sv/thp_pkg.sv
// Shared types and constants of the typed handle pool with its write cache.
package thp_pkg;

   localparam int HANDLES_PER_KIND = 32;
   localparam int CACHE_DEPTH      = 16;
   localparam int HANDLE_W         = $clog2(2 * HANDLES_PER_KIND);
   localparam int RING_AW          = $clog2(HANDLES_PER_KIND);
   localparam int POOL_CW          = $clog2(HANDLES_PER_KIND + 1);
   localparam int CACHE_AW         = $clog2(CACHE_DEPTH);
   localparam int CACHE_CW         = $clog2(CACHE_DEPTH + 1);
   localparam int KEY_W            = 35;

   // Operation codes of a request word.
   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_EVICT   = 2'd2;
   // Spare code; the block answers it without changing anything.
   localparam logic [1:0] OP_NONE    = 2'd3;

   // Register indexes on the configuration port.
   localparam logic REG_CACHE_ENABLE = 1'b0;
   localparam logic REG_CACHE_LIMIT  = 1'b1;

   typedef logic [HANDLE_W-1:0] handle_type;
   typedef logic [KEY_W-1:0]    key_type;

   // Commands to the free-list unit.
   typedef struct packed {
      logic       pop;
      logic       pop_kind;
      logic       push;
      handle_type push_handle;
   } pool_cmd_type;

   // Commands to the cache unit.
   typedef struct packed {
      logic                look_zero;
      logic [CACHE_AW-1:0] look_idx;
      logic                evict;
      logic                insert;
      handle_type          ins_handle;
   } cache_cmd_type;

endpackage

// File: sv/typed_handle_pool_with_fifo_cache.sv
// Steps of a request word once taken: a release, a granted plain allocation or an evict word
// that needs no eviction passes the dispatch and finish states, and the plain path or an
// evict word also visits the eviction step when it needs it; a cached write allocation scans
// the cache, one cache entry compared per cycle by a single comparator, before it finishes.
// One request word at a time; the next is taken the cycle after the result is taken.
// Reset (synchronous): free lists refilled in order, cache emptied, all handles idle, defaults.
module typed_handle_pool_with_fifo_cache (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic        req_io_kind,
   input  logic        req_to_nvram,
   input  logic        req_partial,
   input  logic [31:0] req_page_number,
   input  logic [2:0]  req_array_index,
   input  logic [5:0]  req_handle_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_granted,
   output logic [5:0]  rsp_handle_out,
   output logic        rsp_cache_hit,
   output logic        rsp_evicted_valid,
   output logic [5:0]  rsp_evicted_handle,
   output logic        rsp_read_pool_empty,
   output logic        rsp_write_pool_empty,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DISP   = 3'd1;
   localparam logic [2:0] S_LOOK   = 3'd2;
   localparam logic [2:0] S_MISS   = 3'd3;
   localparam logic [2:0] S_EVICT  = 3'd4;
   localparam logic [2:0] S_INSERT = 3'd5;
   localparam logic [2:0] S_FIN    = 3'd6;

   logic [2:0]                      state_ff, state_in;
   logic                            cfg_en_ff;
   logic [4:0]                      cfg_lim_ff;
   logic [1:0]                      op_ff;
   logic                            kind_ff, cpath_ff;
   thp_pkg::key_type                key_ff;
   thp_pkg::handle_type             hin_ff, new_h_ff, new_h_in;
   logic                            ins_ff, ins_in;
   logic [thp_pkg::CACHE_CW-1:0]    look_ff, look_in;
   logic                            grant_ff, grant_in, hit_ff, hit_in, ev_ff, ev_in;
   thp_pkg::handle_type             hout_ff, hout_in, evh_ff, evh_in;
   logic                            rsp_valid_ff, rempty_ff, wempty_ff;
   logic [2*thp_pkg::HANDLES_PER_KIND-1:0] busy_ff, busy_in, cached_ff, cached_in;
   logic [thp_pkg::CACHE_CW-1:0]    lim;
   logic                            accept, cfg_wr;

   thp_pkg::pool_cmd_type           pool_cmd;
   thp_pkg::cache_cmd_type          cache_cmd;
   thp_pkg::handle_type             pop_handle, rd_handle;
   logic [thp_pkg::POOL_CW-1:0]     read_count, write_count;
   logic [thp_pkg::CACHE_CW-1:0]    cache_count;
   logic                            match;

   thp_pool u_pool (
      .clock       (clock),
      .reset       (reset),
      .cmd         (pool_cmd),
      .pop_handle  (pop_handle),
      .read_count  (read_count),
      .write_count (write_count)
   );

   thp_cache u_cache (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cache_cmd),
      .key       (key_ff),
      .match     (match),
      .rd_handle (rd_handle),
      .count     (cache_count)
   );

   // Handshakes.
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign cfg_wr    = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == thp_pkg::REG_CACHE_LIMIT) ? {27'd0, cfg_lim_ff}
                                                             : {31'd0, cfg_en_ff};

   // Effective cache limit, clamped to one and to the cache depth.
   always_comb begin
      if (cfg_lim_ff == '0) begin
         lim = thp_pkg::CACHE_CW'(1);
      end else if (cfg_lim_ff > 5'(thp_pkg::CACHE_DEPTH)) begin
         lim = thp_pkg::CACHE_CW'(thp_pkg::CACHE_DEPTH);
      end else begin
         lim = thp_pkg::CACHE_CW'(cfg_lim_ff);
      end
   end

   // Sequencer: one step of the request each cycle.
   always_comb begin
      state_in  = state_ff;
      look_in   = look_ff;
      ins_in    = ins_ff;
      new_h_in  = new_h_ff;
      grant_in  = grant_ff;
      hout_in   = hout_ff;
      hit_in    = hit_ff;
      ev_in     = ev_ff;
      evh_in    = evh_ff;
      busy_in   = busy_ff;
      cached_in = cached_ff;
      pool_cmd  = '0;
      cache_cmd = '0;
      cache_cmd.look_idx   = look_ff[thp_pkg::CACHE_AW-1:0];
      cache_cmd.ins_handle = new_h_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_DISP;
               grant_in = 1'b0;
               hout_in  = '0;
               hit_in   = 1'b0;
               ev_in    = 1'b0;
               evh_in   = '0;
               ins_in   = 1'b0;
               look_in  = '0;
            end
         end
         S_DISP: begin
            state_in = S_FIN;
            case (op_ff)
               thp_pkg::OP_ALLOC: begin
                  if (cpath_ff) begin
                     state_in = S_LOOK;
                  end else if ((kind_ff ? write_count : read_count) != '0) begin
                     pool_cmd.pop      = 1'b1;
                     pool_cmd.pop_kind = kind_ff;
                     busy_in[pop_handle] = 1'b1;
                     grant_in = 1'b1;
                     hout_in  = pop_handle;
                  end else begin
                     state_in = S_EVICT;
                  end
               end
               thp_pkg::OP_RELEASE: begin
                  if (busy_ff[hin_ff]) begin
                     busy_in[hin_ff] = 1'b0;
                     if (!cached_ff[hin_ff]) begin
                        pool_cmd.push        = 1'b1;
                        pool_cmd.push_handle = hin_ff;
                     end
                  end
               end
               thp_pkg::OP_EVICT: begin
                  if (write_count == '0) begin
                     state_in = S_EVICT;
                  end
               end
               default: begin
                  state_in = S_FIN;
               end
            endcase
         end
         S_LOOK: begin
            if (look_ff == cache_count) begin
               state_in = S_MISS;
            end else if (match) begin
               grant_in = 1'b1;
               hit_in   = 1'b1;
               hout_in  = rd_handle;
               busy_in[rd_handle] = 1'b1;
               state_in = S_FIN;
            end else begin
               look_in = look_ff + 1'b1;
            end
         end
         S_MISS: begin
            if (write_count == '0) begin
               state_in = S_FIN;
            end else begin
               pool_cmd.pop      = 1'b1;
               pool_cmd.pop_kind = 1'b1;
               busy_in[pop_handle] = 1'b1;
               grant_in = 1'b1;
               hout_in  = pop_handle;
               new_h_in = pop_handle;
               if (cache_count >= lim) begin
                  ins_in   = 1'b1;
                  state_in = S_EVICT;
               end else begin
                  state_in = S_INSERT;
               end
            end
         end
         S_EVICT: begin
            cache_cmd.look_zero = 1'b1;
            if (cache_count != '0) begin
               cache_cmd.evict = 1'b1;
               cached_in[rd_handle] = 1'b0;
               if (!busy_ff[rd_handle]) begin
                  pool_cmd.push        = 1'b1;
                  pool_cmd.push_handle = rd_handle;
               end
               ev_in  = 1'b1;
               evh_in = rd_handle;
            end
            state_in = ins_ff ? S_INSERT : S_FIN;
         end
         S_INSERT: begin
            cache_cmd.insert = 1'b1;
            if (cache_count < thp_pkg::CACHE_CW'(thp_pkg::CACHE_DEPTH)) begin
               cached_in[new_h_ff] = 1'b1;
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= '0;
         cached_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         cfg_en_ff    <= 1'b1;
         cfg_lim_ff   <= 5'd16;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= busy_in;
         cached_ff <= cached_in;
         if (state_ff == S_FIN) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cfg_wr) begin
            if (paddr[2] == thp_pkg::REG_CACHE_ENABLE) begin
               cfg_en_ff <= pwdata[0];
            end else begin
               cfg_lim_ff <= pwdata[4:0];
            end
         end
      end
   end

   // Request fields and result word.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_operation;
         kind_ff  <= req_io_kind;
         key_ff   <= {req_array_index, req_page_number};
         hin_ff   <= req_handle_in;
         cpath_ff <= cfg_en_ff && req_to_nvram && req_partial && req_io_kind;
      end
      look_ff  <= look_in;
      ins_ff   <= ins_in;
      new_h_ff <= new_h_in;
      grant_ff <= grant_in;
      hout_ff  <= hout_in;
      hit_ff   <= hit_in;
      ev_ff    <= ev_in;
      evh_ff   <= evh_in;
      if (state_ff == S_FIN) begin
         rempty_ff <= (read_count == '0);
         wempty_ff <= (write_count == '0);
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_granted          = grant_ff;
   assign rsp_handle_out       = hout_ff;
   assign rsp_cache_hit        = hit_ff;
   assign rsp_evicted_valid    = ev_ff;
   assign rsp_evicted_handle   = evh_ff;
   assign rsp_read_pool_empty  = rempty_ff;
   assign rsp_write_pool_empty = wempty_ff;

`ifndef SYNTHESIS
   a_hit_granted : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_cache_hit || rsp_granted))
      else $error("cache hit reported without a grant");
   a_handle_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_granted) |-> (rsp_handle_out == '0))
      else $error("handle given without a grant");
   a_cache_fill : assert property (@(posedge clock) disable iff (reset)
      cache_count <= thp_pkg::CACHE_CW'(thp_pkg::CACHE_DEPTH))
      else $error("cache fill beyond its depth");
   a_one_word : assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_DISP) && !rsp_valid)
      else $error("request taken while another was in flight");
`endif

endmodule

// File: sv/thp_pool.sv
// Two circular free lists of handles, one for read and one for write handles.
module thp_pool (
   input  logic                               clock,
   input  logic                               reset,
   input  thp_pkg::pool_cmd_type              cmd,
   output thp_pkg::handle_type                pop_handle,
   output logic [thp_pkg::POOL_CW-1:0]        read_count,
   output logic [thp_pkg::POOL_CW-1:0]        write_count
);

   thp_pkg::handle_type                ring_ff [2][thp_pkg::HANDLES_PER_KIND];
   logic [thp_pkg::RING_AW-1:0]        head_ff [2];
   logic [thp_pkg::RING_AW-1:0]        tail_ff [2];
   logic [thp_pkg::POOL_CW-1:0]        cnt_ff  [2];
   logic                               push_kind;

   assign push_kind   = cmd.push_handle[thp_pkg::HANDLE_W-1];
   assign pop_handle  = ring_ff[cmd.pop_kind][head_ff[cmd.pop_kind]];
   assign read_count  = cnt_ff[0];
   assign write_count = cnt_ff[1];

   // Reset fills each list in handle order; pop takes the head, push adds at the tail.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 2; k++) begin
            for (int i = 0; i < thp_pkg::HANDLES_PER_KIND; i++) begin
               ring_ff[k][i] <= thp_pkg::HANDLE_W'(k * thp_pkg::HANDLES_PER_KIND + i);
            end
            head_ff[k] <= '0;
            tail_ff[k] <= '0;
            cnt_ff[k]  <= thp_pkg::POOL_CW'(thp_pkg::HANDLES_PER_KIND);
         end
      end else begin
         if (cmd.pop && cnt_ff[cmd.pop_kind] != '0) begin
            head_ff[cmd.pop_kind] <= head_ff[cmd.pop_kind] + 1'b1;
            cnt_ff[cmd.pop_kind]  <= cnt_ff[cmd.pop_kind] - 1'b1;
         end else if (cmd.push &&
                      cnt_ff[push_kind] < thp_pkg::POOL_CW'(thp_pkg::HANDLES_PER_KIND)) begin
            ring_ff[push_kind][tail_ff[push_kind]] <= cmd.push_handle;
            tail_ff[push_kind] <= tail_ff[push_kind] + 1'b1;
            cnt_ff[push_kind]  <= cnt_ff[push_kind] + 1'b1;
         end
      end
   end

endmodule

// File: sv/thp_cache.sv
// FIFO write cache: key and handle stores, age pointers and the shared key comparator.
module thp_cache (
   input  logic                               clock,
   input  logic                               reset,
   input  thp_pkg::cache_cmd_type             cmd,
   input  thp_pkg::key_type                   key,
   output logic                               match,
   output thp_pkg::handle_type                rd_handle,
   output logic [thp_pkg::CACHE_CW-1:0]       count
);

   thp_pkg::key_type              key_mem [thp_pkg::CACHE_DEPTH];
   thp_pkg::handle_type           hnd_mem [thp_pkg::CACHE_DEPTH];
   logic [thp_pkg::CACHE_AW-1:0]  head_ff;
   logic [thp_pkg::CACHE_AW-1:0]  tail_ff;
   logic [thp_pkg::CACHE_CW-1:0]  count_ff;
   logic [thp_pkg::CACHE_AW-1:0]  addr;

   // One entry is examined per cycle, counted from the oldest.
   assign addr      = cmd.look_zero ? head_ff : head_ff + cmd.look_idx;
   assign match     = (key_mem[addr] == key);
   assign rd_handle = hnd_mem[addr];
   assign count     = count_ff;

   // Stores hold no reset; only entries between head and fill are ever read.
   always_ff @(posedge clock) begin
      if (cmd.insert && count_ff < thp_pkg::CACHE_CW'(thp_pkg::CACHE_DEPTH)) begin
         key_mem[tail_ff] <= key;
         hnd_mem[tail_ff] <= cmd.ins_handle;
      end
   end

   // Age pointers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.evict && count_ff != '0) begin
         head_ff  <= head_ff + 1'b1;
         count_ff <= count_ff - 1'b1;
      end else if (cmd.insert && count_ff < thp_pkg::CACHE_CW'(thp_pkg::CACHE_DEPTH)) begin
         tail_ff  <= tail_ff + 1'b1;
         count_ff <= count_ff + 1'b1;
      end
   end

endmodule

// File: tb/sv/thp_checker.sv
// Checker for the typed handle pool: predicts every result word and compares it.
`timescale 1ns / 100ps
module thp_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic        req_io_kind,
   input  logic        req_to_nvram,
   input  logic        req_partial,
   input  logic [31:0] req_page_number,
   input  logic [2:0]  req_array_index,
   input  logic [5:0]  req_handle_in,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_granted,
   input  logic [5:0]  rsp_handle_out,
   input  logic        rsp_cache_hit,
   input  logic        rsp_evicted_valid,
   input  logic [5:0]  rsp_evicted_handle,
   input  logic        rsp_read_pool_empty,
   input  logic        rsp_write_pool_empty,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   input  logic        end_of_test,
   output int          errors,
   output int          hits_seen,
   output int          evictions_seen
);

   localparam int NUM_HANDLES = 2 * thp_pkg::HANDLES_PER_KIND;

   typedef struct packed {
      logic                granted;
      thp_pkg::handle_type handle_out;
      logic                cache_hit;
      logic                evicted_valid;
      thp_pkg::handle_type evicted_handle;
      logic                read_pool_empty;
      logic                write_pool_empty;
   } grant_word_type;

   // Private copy of the pool and cache state.
   thp_pkg::handle_type read_ring [thp_pkg::HANDLES_PER_KIND];
   thp_pkg::handle_type write_ring [thp_pkg::HANDLES_PER_KIND];
   int                  free_count [2];
   int                  ring_head [2];
   int                  ring_tail [2];
   thp_pkg::key_type    entry_key [thp_pkg::CACHE_DEPTH];
   thp_pkg::handle_type entry_handle [thp_pkg::CACHE_DEPTH];
   int                  age_head, age_tail, age_fill;
   bit                  is_cached [NUM_HANDLES];
   bit                  is_busy [NUM_HANDLES];
   bit                  enable_reg;
   int                  limit_reg;

   grant_word_type expected_words [$];
   bit             end_seen;

   task automatic report(input string what);
      $display("[%0t] checker: %s", $realtime, what);
      errors++;
   endtask

   task automatic clear_state();
      for (int i = 0; i < thp_pkg::HANDLES_PER_KIND; i++) begin
         read_ring[i]  = thp_pkg::handle_type'(i);
         write_ring[i] = thp_pkg::handle_type'(thp_pkg::HANDLES_PER_KIND + i);
      end
      for (int k = 0; k < 2; k++) begin
         free_count[k] = thp_pkg::HANDLES_PER_KIND;
         ring_head[k]  = 0;
         ring_tail[k]  = 0;
      end
      age_head = 0;
      age_tail = 0;
      age_fill = 0;
      for (int i = 0; i < NUM_HANDLES; i++) begin
         is_cached[i] = 0;
         is_busy[i]   = 0;
      end
      enable_reg = 1;
      limit_reg  = 16;
   endtask

   task automatic take_free(input int kind, output bit ok, output thp_pkg::handle_type h);
      ok = 0;
      h  = '0;
      if (free_count[kind] != 0) begin
         h = (kind != 0) ? write_ring[ring_head[kind]] : read_ring[ring_head[kind]];
         ring_head[kind] = (ring_head[kind] + 1) % thp_pkg::HANDLES_PER_KIND;
         free_count[kind]--;
         ok = 1;
      end
   endtask

   task automatic give_free(input thp_pkg::handle_type h);
      int kind;
      kind = (h >= thp_pkg::HANDLES_PER_KIND) ? 1 : 0;
      if (free_count[kind] < thp_pkg::HANDLES_PER_KIND) begin
         if (kind != 0) write_ring[ring_tail[kind]] = h;
         else read_ring[ring_tail[kind]] = h;
         ring_tail[kind] = (ring_tail[kind] + 1) % thp_pkg::HANDLES_PER_KIND;
         free_count[kind]++;
      end
   endtask

   task automatic drop_oldest(output bit ok, output thp_pkg::handle_type h);
      ok = 0;
      h  = '0;
      if (age_fill != 0) begin
         h = entry_handle[age_head];
         age_head = (age_head + 1) % thp_pkg::CACHE_DEPTH;
         age_fill--;
         is_cached[h] = 0;
         if (!is_busy[h]) give_free(h);
         ok = 1;
      end
   endtask

   // Works out the result word of one request word and moves the state on.
   task automatic predict_grant(input logic [1:0] op, input logic kind, input logic nvram,
                                input logic part, input logic [31:0] page,
                                input logic [2:0] arr, input thp_pkg::handle_type hin,
                                output grant_word_type w);
      thp_pkg::key_type    key;
      thp_pkg::handle_type h;
      bit                  ok, ev_ok;
      int                  lim, idx;
      key = {arr, page};
      w   = '0;
      case (op)
         thp_pkg::OP_ALLOC: begin
            if (enable_reg && nvram && part && kind) begin
               for (int i = 0; i < age_fill && !w.cache_hit; i++) begin
                  idx = (age_head + i) % thp_pkg::CACHE_DEPTH;
                  if (entry_key[idx] == key) begin
                     w.cache_hit  = 1;
                     w.handle_out = entry_handle[idx];
                  end
               end
               if (w.cache_hit) begin
                  w.granted = 1;
                  is_busy[w.handle_out] = 1;
               end else begin
                  take_free(1, ok, h);
                  if (ok) begin
                     lim = (limit_reg == 0) ? 1 :
                           (limit_reg > thp_pkg::CACHE_DEPTH) ? thp_pkg::CACHE_DEPTH
                                                              : limit_reg;
                     if (age_fill >= lim) begin
                        drop_oldest(ev_ok, w.evicted_handle);
                        w.evicted_valid = ev_ok;
                     end
                     is_busy[h] = 1;
                     if (age_fill < thp_pkg::CACHE_DEPTH) begin
                        entry_key[age_tail]    = key;
                        entry_handle[age_tail] = h;
                        age_tail = (age_tail + 1) % thp_pkg::CACHE_DEPTH;
                        age_fill++;
                        is_cached[h] = 1;
                     end
                     w.granted    = 1;
                     w.handle_out = h;
                  end
               end
            end else begin
               take_free(kind, ok, h);
               if (ok) begin
                  is_busy[h]   = 1;
                  w.granted    = 1;
                  w.handle_out = h;
               end else begin
                  drop_oldest(ev_ok, w.evicted_handle);
                  w.evicted_valid = ev_ok;
               end
            end
         end
         thp_pkg::OP_RELEASE: begin
            if (is_busy[hin]) begin
               is_busy[hin] = 0;
               if (!is_cached[hin]) give_free(hin);
            end
         end
         thp_pkg::OP_EVICT: begin
            if (free_count[1] == 0) begin
               drop_oldest(ev_ok, w.evicted_handle);
               w.evicted_valid = ev_ok;
            end
         end
         default: ;
      endcase
      w.read_pool_empty  = (free_count[0] == 0);
      w.write_pool_empty = (free_count[1] == 0);
   endtask

   // Monitor of all three ports, sampled at the rising edge.
   always @(posedge clock) begin
      grant_word_type w, got;
      if (reset) begin
         clear_state();
         expected_words.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == {thp_pkg::REG_CACHE_ENABLE, 2'b00}) enable_reg = pwdata[0];
            else if (paddr == {thp_pkg::REG_CACHE_LIMIT, 2'b00})
               limit_reg = int'(pwdata[4:0]);
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_granted, rsp_handle_out, rsp_cache_hit, rsp_evicted_valid,
                   rsp_evicted_handle, rsp_read_pool_empty, rsp_write_pool_empty};
            if (expected_words.size() == 0) begin
               report("result word with nothing expected");
            end else begin
               w = expected_words[0];
               expected_words.delete(0);
               if (got.granted != w.granted)
                  report($sformatf("granted %0d, expected %0d", got.granted, w.granted));
               if (got.handle_out != w.handle_out)
                  report($sformatf("handle_out %0d, expected %0d", got.handle_out,
                                   w.handle_out));
               if (got.cache_hit != w.cache_hit)
                  report($sformatf("cache_hit %0d, expected %0d", got.cache_hit,
                                   w.cache_hit));
               if (got.evicted_valid != w.evicted_valid)
                  report($sformatf("evicted_valid %0d, expected %0d", got.evicted_valid,
                                   w.evicted_valid));
               if (got.evicted_handle != w.evicted_handle)
                  report($sformatf("evicted_handle %0d, expected %0d", got.evicted_handle,
                                   w.evicted_handle));
               if (got.read_pool_empty != w.read_pool_empty)
                  report($sformatf("read_pool_empty %0d, expected %0d",
                                   got.read_pool_empty, w.read_pool_empty));
               if (got.write_pool_empty != w.write_pool_empty)
                  report($sformatf("write_pool_empty %0d, expected %0d",
                                   got.write_pool_empty, w.write_pool_empty));
               if (w.cache_hit) hits_seen++;
               if (w.evicted_valid) evictions_seen++;
            end
         end
         if (req_valid && !req_stall) begin
            predict_grant(req_operation, req_io_kind, req_to_nvram, req_partial,
                          req_page_number, req_array_index, req_handle_in, w);
            expected_words.push_back(w);
         end
         if (end_of_test && !end_seen) begin
            end_seen = 1;
            if (expected_words.size() != 0)
               report($sformatf("%0d result words never arrived", expected_words.size()));
         end
      end
   end

   initial begin
      errors         = 0;
      hits_seen      = 0;
      evictions_seen = 0;
      end_seen       = 0;
   end

endmodule

// File: tb/sv/tb.sv
// Top of the handle pool testbench: clock, reset, stimulus and the verdict.
`timescale 1ns / 100ps
module tb;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_operation = thp_pkg::OP_ALLOC;
   logic        req_io_kind = 0;
   logic        req_to_nvram = 0;
   logic        req_partial = 0;
   logic [31:0] req_page_number = '0;
   logic [2:0]  req_array_index = '0;
   logic [5:0]  req_handle_in = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic        rsp_granted;
   logic [5:0]  rsp_handle_out;
   logic        rsp_cache_hit;
   logic        rsp_evicted_valid;
   logic [5:0]  rsp_evicted_handle;
   logic        rsp_read_pool_empty;
   logic        rsp_write_pool_empty;
   logic        psel = 0;
   logic        penable = 0;
   logic        pwrite = 0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   logic        end_of_test = 0;
   int          errors, hits_seen, evictions_seen;
   int          words_sent = 0, words_back = 0, cycles = 0;
   int          burst_left = 0, alloc_weight = 60;
   thp_pkg::handle_type held_handles [$];

   typed_handle_pool_with_fifo_cache DUT (.*);

   thp_checker checker_i (.*);

   always #5 clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("typed_handle_pool_with_fifo_cache: mismatch");
         $finish;
      end
   end

   // Receiver stall pattern: steps in turn through no stall, random, periodic and rare stalls.
   always @(posedge clock) begin
      case ((cycles / 128) % 4)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 1) == 1);
         2: rsp_stall <= ((cycles % 16) < 11);
         default: rsp_stall <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Keeps the handles handed out, so most releases name a busy handle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         words_back++;
         if (rsp_granted) held_handles.push_back(rsp_handle_out);
      end
   end

   task automatic csr_write(input logic idx, input logic [31:0] value);
      @(posedge clock);
      psel    <= 1;
      pwrite  <= 1;
      penable <= 0;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel    <= 0;
      penable <= 0;
      pwrite  <= 0;
   endtask

   // Waits until every result word is back, then lets the block settle.
   task automatic drain();
      @(posedge clock);
      req_valid <= 0;
      while (words_back != words_sent) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   // Offers one word and waits for it to be taken; bursts and gaps between words.
   task automatic send_word(input logic [1:0] op, input logic kind, input logic nvram,
                            input logic part, input logic [31:0] page,
                            input logic [2:0] arr, input logic [5:0] hin);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            @(posedge clock);
            req_valid <= 0;
            repeat ($urandom_range(0, 6)) @(posedge clock);
         end
      end
      burst_left--;
      @(posedge clock);
      req_valid       <= 1;
      req_operation   <= op;
      req_io_kind     <= kind;
      req_to_nvram    <= nvram;
      req_partial     <= part;
      req_page_number <= page;
      req_array_index <= arr;
      req_handle_in   <= hin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   task automatic random_word();
      int         pick, idx;
      logic [1:0] op;
      logic       kind, nvram, part;
      logic [31:0] page;
      logic [5:0] hin;
      pick  = $urandom_range(0, 99);
      kind  = $urandom_range(0, 3) != 0;
      nvram = $urandom_range(0, 4) != 0;
      part  = $urandom_range(0, 4) != 0;
      page  = ($urandom_range(0, 4) == 0) ? $urandom() : 32'($urandom_range(0, 9));
      hin   = 6'($urandom_range(0, 63));
      if (pick < alloc_weight) op = thp_pkg::OP_ALLOC;
      else if (pick < 93) op = thp_pkg::OP_RELEASE;
      else if (pick < 98) op = thp_pkg::OP_EVICT;
      else op = thp_pkg::OP_NONE;
      if (op == thp_pkg::OP_RELEASE && held_handles.size() != 0 &&
          $urandom_range(0, 4) != 0) begin
         idx = $urandom_range(0, held_handles.size() - 1);
         hin = held_handles[idx];
         held_handles.delete(idx);
      end
      send_word(op, kind, nvram, part, page, 3'($urandom_range(0, 7)), hin);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;

      // Directed words: both paths, every operation and the odd cases.
      send_word(thp_pkg::OP_ALLOC, 0, 0, 0, 32'h0, 3'd0, 6'd0);
      send_word(thp_pkg::OP_ALLOC, 1, 0, 0, 32'h0, 3'd0, 6'd0);
      send_word(thp_pkg::OP_ALLOC, 1, 1, 1, 32'h0, 3'd0, 6'd0);
      send_word(thp_pkg::OP_ALLOC, 1, 1, 1, 32'h0, 3'd0, 6'd0);
      send_word(thp_pkg::OP_ALLOC, 1, 1, 1, 32'hFFFF_FFFF, 3'd7, 6'd0);
      send_word(thp_pkg::OP_ALLOC, 1, 1, 0, 32'hFFFF_FFFF, 3'd7, 6'd0);
      send_word(thp_pkg::OP_ALLOC, 1, 0, 1, 32'hFFFF_FFFF, 3'd7, 6'd0);
      send_word(thp_pkg::OP_ALLOC, 0, 1, 1, 32'h5555_AAAA, 3'd2, 6'd0);
      send_word(thp_pkg::OP_RELEASE, 1, 0, 0, 32'h0, 3'd0, 6'd0);
      send_word(thp_pkg::OP_RELEASE, 0, 0, 0, 32'h0, 3'd0, 6'd0);
      send_word(thp_pkg::OP_RELEASE, 0, 0, 0, 32'h0, 3'd0, 6'd32);
      send_word(thp_pkg::OP_RELEASE, 1, 0, 0, 32'h0, 3'd0, 6'd33);
      send_word(thp_pkg::OP_ALLOC, 1, 1, 1, 32'h0, 3'd0, 6'd0);
      send_word(thp_pkg::OP_RELEASE, 0, 1, 1, 32'h0, 3'd0, 6'd63);
      send_word(thp_pkg::OP_EVICT, 1, 1, 1, 32'hAAAA_5555, 3'd5, 6'd63);
      send_word(thp_pkg::OP_NONE, 1, 1, 1, 32'hFFFF_FFFF, 3'd7, 6'd63);
      drain();

      // Phases of random words over a spread of register settings.
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin
               csr_write(thp_pkg::REG_CACHE_ENABLE, 32'd1);
               csr_write(thp_pkg::REG_CACHE_LIMIT, 32'd16);
            end
            1: csr_write(thp_pkg::REG_CACHE_LIMIT, 32'd1);
            2: csr_write(thp_pkg::REG_CACHE_LIMIT, 32'd0);
            3: csr_write(thp_pkg::REG_CACHE_LIMIT, 32'hFFFF_FFFF);
            4: csr_write(thp_pkg::REG_CACHE_ENABLE, 32'd0);
            5: begin
               csr_write(thp_pkg::REG_CACHE_ENABLE, 32'hFFFF_FFFF);
               csr_write(thp_pkg::REG_CACHE_LIMIT, 32'd5);
            end
            default: csr_write(thp_pkg::REG_CACHE_LIMIT, 32'd16);
         endcase
         alloc_weight = (phase % 2 == 0) ? 70 : 50;
         repeat (72) random_word();
         drain();
      end

      end_of_test <= 1;
      repeat (2) @(posedge clock);
      $display("sent %0d request words over seven register settings", words_sent);
      $display("cache hits %0d, evictions %0d", hits_seen, evictions_seen);
      if (errors == 0) begin
         $display("typed_handle_pool_with_fifo_cache: match");
      end else begin
         $display("typed_handle_pool_with_fifo_cache: mismatch");
      end
      $finish;
   end

endmodule
